// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define HRF_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrf assertion failed");

// Next-cycle implication, disabled while reset is high
`define HRF_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrf assertion failed");

`endif

// ===== design/hrf_pkg.sv =====
// ----------------------------------------------------------------------------
// hrf_pkg
// Widths and fixed record constants of the hex record framer.
// ----------------------------------------------------------------------------
package hrf_pkg;

   localparam int WORD_W  = 32;
   localparam int COUNT_W = 3;
   localparam int ADDR_W  = 16;
   localparam int BYTE_W  = 8;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [WORD_W-1:0]  word_type;
   typedef logic [COUNT_W-1:0] count_type;

   localparam count_type MAX_WORD_BYTES = 3'd4;
   localparam byte_type  REC_TYPE_DATA  = 8'h00;

   // End record: 00 00 00 01 FF
   localparam logic [2:0] END_LAST_IDX = 3'd4;

   function automatic byte_type end_record_byte(input logic [2:0] idx);
      byte_type b;
      case (idx)
         3'd3:    b = 8'h01;
         3'd4:    b = 8'hFF;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ===== design/hrf_ram.sv =====
// ----------------------------------------------------------------------------
// hrf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hrf_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/hex_record_framer.sv =====
// ----------------------------------------------------------------------------
// hex_record_framer
// Packs 1- to 4-byte code words into binary Intel HEX data records.
// ----------------------------------------------------------------------------
// One item is taken at a time; its bytes are then written one by one into the
// buffer RAM (one write port). Each record then drains at one byte per cycle
// unless held by rsp_stall: length, address, type, fill data bytes and
// checksum for a data record, five fixed bytes for the end record that
// req_end_of_input asks for after any pending data record. Data bytes are
// read from the RAM at idx_in so the registered read data matches idx_ff.
// req_stall is high while an item is being worked on. Writing base_address
// (csr_write_*) sets the address of the next record emitted.
// ----------------------------------------------------------------------------
module hex_record_framer #(
   parameter int RECORD_BYTES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  hrf_pkg::addr_type      csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  hrf_pkg::word_type      req_word_value,
   input  hrf_pkg::count_type     req_byte_count,
   input  logic                   req_end_of_input,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hrf_pkg::byte_type      rsp_record_byte,
   output logic                   rsp_record_begin,
   output logic                   rsp_last_of_run
);
   import hrf_pkg::*;

   localparam int FILL_W = $clog2(RECORD_BYTES + 1);
   localparam int IDX_W  = $clog2(RECORD_BYTES);
   localparam logic [FILL_W-1:0] RB_FILL = FILL_W'(RECORD_BYTES);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_APPEND = 4'd1;
   localparam logic [3:0] S_LEN    = 4'd2;
   localparam logic [3:0] S_ADRH   = 4'd3;
   localparam logic [3:0] S_ADRL   = 4'd4;
   localparam logic [3:0] S_TYPE   = 4'd5;
   localparam logic [3:0] S_DATA   = 4'd6;
   localparam logic [3:0] S_CSUM   = 4'd7;
   localparam logic [3:0] S_END    = 4'd8;

   // What follows a data record
   localparam logic [1:0] AFTER_IDLE   = 2'd0;
   localparam logic [1:0] AFTER_APPEND = 2'd1;
   localparam logic [1:0] AFTER_END    = 2'd2;

   logic [3:0]        state_ff, state_in;
   logic [1:0]        after_ff, after_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   addr_type          addr_ff, addr_in;
   word_type          word_ff, word_in;
   count_type         cnt_ff, cnt_in;
   logic [1:0]        bi_ff, bi_in;
   logic [2:0]        ecnt_ff, ecnt_in;
   byte_type          sum_ff, sum_in;

   logic              rsp_valid_ff;
   byte_type          rsp_byte_ff;
   logic              rsp_begin_ff;
   logic              rsp_last_ff;

   logic              ram_we;
   byte_type          ram_wdata;
   byte_type          ram_rdata;

   logic              out_free;
   logic              emit_valid;
   logic              emit;
   byte_type          emit_byte;
   logic              emit_begin;
   logic              emit_last;
   count_type         req_cnt_sat;
   logic [FILL_W:0]   fill_plus_req;
   logic [FILL_W-1:0] fill_inc;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit      = emit_valid && out_free;
   assign req_stall = (state_ff != S_IDLE);

   assign req_cnt_sat   = (req_byte_count > MAX_WORD_BYTES) ? MAX_WORD_BYTES : req_byte_count;
   assign fill_plus_req = {1'b0, fill_ff} + (FILL_W + 1)'(req_cnt_sat);
   assign fill_inc      = fill_ff + FILL_W'(1);
   assign ram_wdata     = word_ff[{bi_ff, 3'b000} +: BYTE_W];

   always_comb begin
      state_in   = state_ff;
      after_in   = after_ff;
      fill_in    = fill_ff;
      idx_in     = idx_ff;
      addr_in    = addr_ff;
      word_in    = word_ff;
      cnt_in     = cnt_ff;
      bi_in      = bi_ff;
      ecnt_in    = ecnt_ff;
      ram_we     = 1'b0;
      emit_valid = 1'b0;
      emit_byte  = '0;
      emit_begin = 1'b0;
      emit_last  = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               word_in = req_word_value;
               cnt_in  = req_cnt_sat;
               bi_in   = '0;
               if (req_end_of_input) begin
                  ecnt_in = '0;
                  if (fill_ff != '0) begin
                     state_in = S_LEN;
                     after_in = AFTER_END;
                  end else begin
                     state_in = S_END;
                  end
               end else if (req_cnt_sat != '0) begin
                  // flush first when the word would overflow the record
                  if (fill_ff != '0 && fill_plus_req > {1'b0, RB_FILL}) begin
                     state_in = S_LEN;
                     after_in = AFTER_APPEND;
                  end else begin
                     state_in = S_APPEND;
                  end
               end
            end
         end
         S_APPEND: begin
            ram_we  = 1'b1;
            fill_in = fill_inc;
            bi_in   = bi_ff + 2'd1;
            if ({1'b0, bi_ff} + 3'd1 == cnt_ff) begin
               if (fill_inc >= RB_FILL) begin
                  state_in = S_LEN;
                  after_in = AFTER_IDLE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_LEN: begin
            emit_valid = 1'b1;
            emit_byte  = BYTE_W'(fill_ff);
            emit_begin = 1'b1;
            if (emit) begin
               state_in = S_ADRH;
            end
         end
         S_ADRH: begin
            emit_valid = 1'b1;
            emit_byte  = addr_ff[15:8];
            if (emit) begin
               state_in = S_ADRL;
            end
         end
         S_ADRL: begin
            emit_valid = 1'b1;
            emit_byte  = addr_ff[7:0];
            if (emit) begin
               state_in = S_TYPE;
            end
         end
         S_TYPE: begin
            emit_valid = 1'b1;
            emit_byte  = REC_TYPE_DATA;
            if (emit) begin
               idx_in   = '0;
               state_in = S_DATA;
            end
         end
         S_DATA: begin
            emit_valid = 1'b1;
            emit_byte  = ram_rdata;
            if (emit) begin
               if (FILL_W'(idx_ff) + FILL_W'(1) == fill_ff) begin
                  idx_in   = '0;
                  state_in = S_CSUM;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_CSUM: begin
            emit_valid = 1'b1;
            emit_byte  = ~sum_ff + 8'd1;
            emit_last  = (after_ff == AFTER_IDLE) ||
                         (after_ff == AFTER_APPEND && FILL_W'(cnt_ff) < RB_FILL);
            if (emit) begin
               addr_in = addr_ff + ADDR_W'(fill_ff);
               fill_in = '0;
               case (after_ff)
                  AFTER_APPEND: state_in = S_APPEND;
                  AFTER_END:    state_in = S_END;
                  default:      state_in = S_IDLE;
               endcase
            end
         end
         S_END: begin
            emit_valid = 1'b1;
            emit_byte  = end_record_byte(ecnt_ff);
            emit_begin = (ecnt_ff == '0);
            emit_last  = (ecnt_ff == END_LAST_IDX);
            if (emit) begin
               if (ecnt_ff == END_LAST_IDX) begin
                  ecnt_in  = '0;
                  state_in = S_IDLE;
               end else begin
                  ecnt_in = ecnt_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         addr_in = csr_write_data;
      end
   end

   // running byte sum of the record, restarted at the length byte
   always_comb begin
      sum_in = sum_ff;
      if (emit) begin
         sum_in = (state_ff == S_LEN) ? emit_byte : sum_ff + emit_byte;
      end
   end

   // read address comes from idx_in so the registered RAM output matches idx_ff
   hrf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (RECORD_BYTES)
   ) u_buf (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff[IDX_W-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         after_ff     <= AFTER_IDLE;
         fill_ff      <= '0;
         idx_ff       <= '0;
         addr_ff      <= '0;
         bi_ff        <= '0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         after_ff <= after_in;
         fill_ff  <= fill_in;
         idx_ff   <= idx_in;
         addr_ff  <= addr_in;
         bi_ff    <= bi_in;
         ecnt_ff  <= ecnt_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      cnt_ff  <= cnt_in;
      sum_ff  <= sum_in;
      if (emit) begin
         rsp_byte_ff  <= emit_byte;
         rsp_begin_ff <= emit_begin;
         rsp_last_ff  <= emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_record_byte  = rsp_byte_ff;
   assign rsp_record_begin = rsp_begin_ff;
   assign rsp_last_of_run  = rsp_last_ff;

endmodule

// ===== design/hrf_checker.sv =====
// ----------------------------------------------------------------------------
// hrf_checker
// Port-level checks of the hex record framer, bound into hex_record_framer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hrf_checker #(
   parameter int RECORD_BYTES = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  hrf_pkg::byte_type      rsp_record_byte,
   input  logic                   rsp_record_begin,
   input  logic                   rsp_last_of_run
);
   import hrf_pkg::*;

   localparam byte_type MAX_LEN = BYTE_W'(RECORD_BYTES);

   // a stalled item stays offered and unchanged
   `HRF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `HRF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall,
      $stable(rsp_record_byte) && $stable(rsp_last_of_run))

   // length byte never exceeds the record size
   `HRF_ASSERT_NOW(a_len_bound, clock, reset, rsp_valid && rsp_record_begin,
      rsp_record_byte <= MAX_LEN)

   // the first (length) byte of a record is never marked last of run
   `HRF_ASSERT_NOW(a_begin_not_last, clock, reset, rsp_valid && rsp_record_begin,
      !rsp_last_of_run)

endmodule

bind hex_record_framer hrf_checker #(.RECORD_BYTES(RECORD_BYTES)) u_hrf_checker (.*);
